FILE: src/trft_pkg.sv
package trft_pkg;

    // Fixed formats of the datapath.
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = 5;
    localparam int CW           = 36;  // CORDIC x and y width
    localparam int ZW           = 34;  // CORDIC angle width
    localparam int MW           = 33;  // multiplier operand width
    localparam int PW           = 2 * MW;
    localparam int AW           = 68;  // accumulator width

    localparam logic [16:0] Q15_ONE = 17'd32768;
    localparam logic signed [CW-1:0] GAIN_INV_Q30 = 36'sd652032874;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ALPHA     = 3'd0;
    localparam logic [2:0] REG_BETA      = 3'd1;
    localparam logic [2:0] REG_GAMMA     = 3'd2;
    localparam logic [2:0] REG_NAT_STEP  = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_VEC,
        ST_DONE
    } state_t;

    // Multiply steps, issued in this order.
    typedef enum logic [4:0] {
        OP_AD_R, OP_AZ_R, OP_TS_R,
        OP_AD_I, OP_AZ_I, OP_TS_I,
        OP_BP_R, OP_BD_R,
        OP_BP_I, OP_BD_I,
        OP_RR, OP_II,
        OP_IR, OP_RI,
        OP_SS_R, OP_SS_I,
        OP_GA
    } op_t;

    typedef struct packed {
        logic start;
        logic vector;
    } cordic_cmd_t;

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic logic signed [ZW-1:0] angle_tab(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round half up by 2^n, then saturate to 32 bits.
    function automatic logic signed [31:0] round_sat32(input logic signed [AW-1:0] v,
                                                       input int n);
        logic signed [AW-1:0] r;
        r = (v + (68'sd1 <<< (n - 1))) >>> n;
        if (r > 68'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (r < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return r[31:0];
    endfunction

    // Round half up by 2^15, then saturate to 16 bits.
    function automatic logic signed [15:0] round_sat16(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + 36'sd16384) >>> 15;
        if (r > 36'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -36'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage

FILE: src/trft_mul.sv
module trft_mul (
    input  logic                          aclk,
    input  logic signed [trft_pkg::MW-1:0] a,
    input  logic signed [trft_pkg::MW-1:0] b,
    output logic signed [trft_pkg::PW-1:0] p
);

    logic signed [trft_pkg::PW-1:0] p_reg;

    // Registered signed product.
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: src/trft_cordic.sv
module trft_cordic (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  trft_pkg::cordic_cmd_t          cmd,
    input  logic signed [trft_pkg::CW-1:0] x0,
    input  logic signed [trft_pkg::CW-1:0] y0,
    input  logic signed [trft_pkg::ZW-1:0] z0,
    output logic                           done,
    output logic signed [trft_pkg::CW-1:0] x,
    output logic signed [trft_pkg::CW-1:0] y,
    output logic signed [trft_pkg::ZW-1:0] z
);

    logic signed [trft_pkg::CW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [trft_pkg::ZW-1:0] z_reg, z_next, ang;
    logic [trft_pkg::CNT_W-1:0]     cnt_reg;
    logic                           busy_reg, vec_reg, done_reg, dir;

    // One micro-rotation per cycle; the direction follows z when rotating
    // and the sign of y when vectoring.
    always_comb begin
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        ang = trft_pkg::angle_tab(cnt_reg);
        dir = vec_reg ? y_reg[trft_pkg::CW-1] : ~z_reg[trft_pkg::ZW-1];
        if (dir) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == trft_pkg::CNT_W'(trft_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= cmd.vector;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

FILE: src/tracking_resonator_frequency_tracker_core.sv
// Frequency-tracking complex resonator. Each input sample is demodulated by
// a phase-accumulator oscillator, smoothed twice, and compared with its
// previous smoothed value; above the power threshold the oscillator step is
// pulled by gamma times the angle of that phase step. Each sample uses one
// shared 16-step CORDIC (used for cos/sin and for the angle) and one
// registered 33x33 multiplier that serves all sixteen products, seventeen
// with tracking, one after another. The input is ready whenever no sample
// is in progress; a finished result waits in the output register while the
// next sample is taken.
module tracking_resonator_frequency_tracker_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_smoothed_real,
    output logic signed [31:0] m_smoothed_imag,
    output logic signed [31:0] m_delta_real,
    output logic signed [31:0] m_delta_imag,
    output logic signed [31:0] m_phase_step,
    output logic               m_tracking
);

    localparam int MW = trft_pkg::MW;
    localparam int AW = trft_pkg::AW;
    localparam int CW = trft_pkg::CW;
    localparam int ZW = trft_pkg::ZW;

    // Configuration registers.
    logic [15:0] alpha_reg, beta_reg, gamma_reg;
    logic [30:0] nat_step_reg;
    logic [31:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= 16'd32768;
            beta_reg     <= 16'd32768;
            gamma_reg    <= 16'd0;
            nat_step_reg <= 31'd0;
            thr_reg      <= 32'd1073742;
        end else if (cfg_we) begin
            priority case (cfg_index)
                trft_pkg::REG_ALPHA:     alpha_reg    <= cfg_wdata[15:0];
                trft_pkg::REG_BETA:      beta_reg     <= cfg_wdata[15:0];
                trft_pkg::REG_GAMMA:     gamma_reg    <= cfg_wdata[15:0];
                trft_pkg::REG_NAT_STEP:  nat_step_reg <= cfg_wdata[30:0];
                trft_pkg::REG_THRESHOLD: thr_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Weights above one act as one.
    logic [16:0] alpha_c, beta_c, gamma_c;
    assign alpha_c = ({1'b0, alpha_reg} > trft_pkg::Q15_ONE) ? trft_pkg::Q15_ONE
                                                             : {1'b0, alpha_reg};
    assign beta_c  = ({1'b0, beta_reg} > trft_pkg::Q15_ONE) ? trft_pkg::Q15_ONE
                                                            : {1'b0, beta_reg};
    assign gamma_c = ({1'b0, gamma_reg} > trft_pkg::Q15_ONE) ? trft_pkg::Q15_ONE
                                                             : {1'b0, gamma_reg};

    // Sequencer and working state.
    trft_pkg::state_t state_reg, state_next;
    trft_pkg::op_t    op_reg, op_next;
    logic             half_reg, half_next;

    logic [31:0]        osc_phase_reg, osc_step_reg, step_new_reg;
    logic signed [31:0] demod_r_reg, demod_i_reg, smooth_r_reg, smooth_i_reg;
    logic signed [31:0] sr_reg, si_reg, dr_reg, di_reg;
    logic signed [15:0] sample_reg, zc_reg, zs_reg;
    logic signed [MW-1:0] t_reg;
    logic signed [AW-1:0] acc_reg;
    logic [1:0]           quad_reg;
    logic                 track_reg;

    logic               out_valid_reg;
    logic signed [31:0] o_sr_reg, o_si_reg, o_dr_reg, o_di_reg, o_step_reg;
    logic               o_track_reg;

    // Shared units.
    trft_pkg::cordic_cmd_t  cmd;
    logic signed [CW-1:0]   c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0]   c_z0, c_z;
    logic                   c_done;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod;

    trft_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .x0      (c_x0),
        .y0      (c_y0),
        .z0      (c_z0),
        .done    (c_done),
        .x       (c_x),
        .y       (c_y),
        .z       (c_z)
    );

    trft_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    logic        in_xfer, out_free;
    logic [1:0]  quad_in;
    logic [31:0] rem_in;
    assign s_ready  = (state_reg == trft_pkg::ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Quadrant folding of the oscillator phase.
    assign quad_in = 2'((osc_phase_reg + 32'h20000000) >> 30);
    assign rem_in  = osc_phase_reg - {quad_in, 30'd0};

    // Quadrant mapping of the rotated vector into cos and sin.
    logic signed [CW-1:0] cos_raw, sin_raw;
    always_comb begin
        unique case (quad_reg)
            2'd0: begin cos_raw = c_x;  sin_raw = c_y;  end
            2'd1: begin cos_raw = -c_y; sin_raw = c_x;  end
            2'd2: begin cos_raw = -c_x; sin_raw = -c_y; end
            default: begin cos_raw = c_y; sin_raw = -c_x; end
        endcase
    end

    // Phase step widened to the CORDIC width for the quarter-turn prerotation before vectoring.
    logic signed [CW-1:0] dr_ext, di_ext;
    assign dr_ext = CW'(dr_reg);
    assign di_ext = CW'(di_reg);

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            trft_pkg::OP_AD_R: begin
                mul_a = MW'(trft_pkg::Q15_ONE - alpha_c); mul_b = MW'(demod_r_reg);
            end
            trft_pkg::OP_AD_I: begin
                mul_a = MW'(trft_pkg::Q15_ONE - alpha_c); mul_b = MW'(demod_i_reg);
            end
            trft_pkg::OP_AZ_R: begin mul_a = MW'(alpha_c); mul_b = MW'(zc_reg); end
            trft_pkg::OP_AZ_I: begin mul_a = MW'(alpha_c); mul_b = MW'(zs_reg); end
            trft_pkg::OP_TS_R,
            trft_pkg::OP_TS_I: begin mul_a = t_reg; mul_b = MW'(sample_reg); end
            trft_pkg::OP_BP_R: begin
                mul_a = MW'(trft_pkg::Q15_ONE - beta_c); mul_b = MW'(smooth_r_reg);
            end
            trft_pkg::OP_BP_I: begin
                mul_a = MW'(trft_pkg::Q15_ONE - beta_c); mul_b = MW'(smooth_i_reg);
            end
            trft_pkg::OP_BD_R: begin mul_a = MW'(beta_c); mul_b = MW'(demod_r_reg); end
            trft_pkg::OP_BD_I: begin mul_a = MW'(beta_c); mul_b = MW'(demod_i_reg); end
            trft_pkg::OP_RR:   begin mul_a = MW'(sr_reg); mul_b = MW'(smooth_r_reg); end
            trft_pkg::OP_II:   begin mul_a = MW'(si_reg); mul_b = MW'(smooth_i_reg); end
            trft_pkg::OP_IR:   begin mul_a = MW'(si_reg); mul_b = MW'(smooth_r_reg); end
            trft_pkg::OP_RI:   begin mul_a = MW'(sr_reg); mul_b = MW'(smooth_i_reg); end
            trft_pkg::OP_SS_R: begin mul_a = MW'(sr_reg); mul_b = MW'(sr_reg); end
            trft_pkg::OP_SS_I: begin mul_a = MW'(si_reg); mul_b = MW'(si_reg); end
            trft_pkg::OP_GA:   begin mul_a = MW'(gamma_c); mul_b = MW'(c_z); end
            default: ;
        endcase
    end

    // Power of the new smoothed value against the threshold.
    logic signed [AW-1:0] acc_plus, acc_minus, power;
    logic                 track_now;
    assign acc_plus  = acc_reg + AW'(prod);
    assign acc_minus = acc_reg - AW'(prod);
    assign power     = acc_plus;
    assign track_now = power > AW'({thr_reg, 30'd0});

    // Next state, next operation and CORDIC commands.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        half_next  = half_reg;
        cmd        = '0;
        c_x0       = trft_pkg::GAIN_INV_Q30;
        c_y0       = '0;
        c_z0       = ZW'($signed(rem_in));
        unique case (state_reg)
            trft_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    cmd.start  = 1'b1;
                    state_next = trft_pkg::ST_ROT;
                end
            end
            trft_pkg::ST_ROT: begin
                if (c_done) begin
                    state_next = trft_pkg::ST_MUL;
                    op_next    = trft_pkg::OP_AD_R;
                    half_next  = 1'b0;
                end
            end
            trft_pkg::ST_MUL: begin
                half_next = ~half_reg;
                if (half_reg) begin
                    if (op_reg == trft_pkg::OP_SS_I) begin
                        if (track_now) begin
                            cmd.start  = 1'b1;
                            cmd.vector = 1'b1;
                            state_next = trft_pkg::ST_VEC;
                            if (dr_reg[31]) begin
                                if (!di_reg[31]) begin
                                    c_x0 = di_ext;
                                    c_y0 = -dr_ext;
                                    c_z0 = trft_pkg::QUARTER_TURN;
                                end else begin
                                    c_x0 = -di_ext;
                                    c_y0 = dr_ext;
                                    c_z0 = -trft_pkg::QUARTER_TURN;
                                end
                            end else begin
                                c_x0 = dr_ext;
                                c_y0 = di_ext;
                                c_z0 = '0;
                            end
                        end else begin
                            state_next = trft_pkg::ST_DONE;
                        end
                    end else if (op_reg == trft_pkg::OP_GA) begin
                        state_next = trft_pkg::ST_DONE;
                    end else begin
                        op_next = trft_pkg::op_t'(op_reg + 1'b1);
                    end
                end
            end
            trft_pkg::ST_VEC: begin
                if (c_done) begin
                    state_next = trft_pkg::ST_MUL;
                    op_next    = trft_pkg::OP_GA;
                    half_next  = 1'b0;
                end
            end
            trft_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = trft_pkg::ST_IDLE;
                end
            end
            default: state_next = trft_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trft_pkg::ST_IDLE;
            op_reg    <= trft_pkg::OP_AD_R;
            half_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            half_reg  <= half_next;
        end
    end

    // Oscillator and smoothing state.
    logic signed [AW-1:0] a_zero_dz;  // zero vector angle is forced to zero
    assign a_zero_dz = (dr_reg == 32'sd0 && di_reg == 32'sd0) ? '0 : AW'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_phase_reg <= '0;
            osc_step_reg  <= '0;
            demod_r_reg   <= '0;
            demod_i_reg   <= '0;
            smooth_r_reg  <= '0;
            smooth_i_reg  <= '0;
        end else begin
            if (state_reg == trft_pkg::ST_MUL && half_reg) begin
                if (op_reg == trft_pkg::OP_TS_R) begin
                    demod_r_reg <= trft_pkg::round_sat32(
                        acc_reg + (AW'(prod) <<< (31 - trft_pkg::SAMPLE_BITS)), 30);
                end
                if (op_reg == trft_pkg::OP_TS_I) begin
                    demod_i_reg <= trft_pkg::round_sat32(
                        acc_reg + (AW'(prod) <<< (31 - trft_pkg::SAMPLE_BITS)), 30);
                end
            end
            if (state_reg == trft_pkg::ST_DONE && out_free) begin
                smooth_r_reg  <= sr_reg;
                smooth_i_reg  <= si_reg;
                osc_step_reg  <= step_new_reg;
                osc_phase_reg <= osc_phase_reg + step_new_reg;
            end
        end
    end

    // Intermediate results of the multiply steps.
    logic signed [AW-1:0] dec;
    assign dec = (a_zero_dz + 68'sd16384) >>> 15;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            sample_reg <= s_sample;
            quad_reg   <= quad_in;
        end
        if (state_reg == trft_pkg::ST_ROT && c_done) begin
            zc_reg <= trft_pkg::round_sat16(cos_raw);
            zs_reg <= trft_pkg::round_sat16(sin_raw);
        end
        if (state_reg == trft_pkg::ST_MUL && half_reg) begin
            unique case (op_reg)
                trft_pkg::OP_AD_R, trft_pkg::OP_AD_I: acc_reg <= AW'(prod) <<< 15;
                trft_pkg::OP_AZ_R, trft_pkg::OP_AZ_I: t_reg <= prod[MW-1:0];
                trft_pkg::OP_BP_R, trft_pkg::OP_BP_I,
                trft_pkg::OP_RR, trft_pkg::OP_IR,
                trft_pkg::OP_SS_R: acc_reg <= AW'(prod);
                trft_pkg::OP_BD_R: sr_reg <= trft_pkg::round_sat32(acc_plus, 15);
                trft_pkg::OP_BD_I: si_reg <= trft_pkg::round_sat32(acc_plus, 15);
                trft_pkg::OP_II:   dr_reg <= trft_pkg::round_sat32(acc_plus, 30);
                trft_pkg::OP_RI:   di_reg <= trft_pkg::round_sat32(acc_minus, 30);
                trft_pkg::OP_SS_I: begin
                    track_reg    <= track_now;
                    step_new_reg <= {1'b0, nat_step_reg};
                end
                trft_pkg::OP_GA:   step_new_reg <= osc_step_reg - dec[31:0];
                default: ;
            endcase
        end
    end

    // Output register; the next sample may enter while a result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == trft_pkg::ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == trft_pkg::ST_DONE && out_free) begin
            o_sr_reg    <= sr_reg;
            o_si_reg    <= si_reg;
            o_dr_reg    <= dr_reg;
            o_di_reg    <= di_reg;
            o_step_reg  <= step_new_reg;
            o_track_reg <= track_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_smoothed_real = o_sr_reg;
    assign m_smoothed_imag = o_si_reg;
    assign m_delta_real    = o_dr_reg;
    assign m_delta_imag    = o_di_reg;
    assign m_phase_step    = o_step_reg;
    assign m_tracking      = o_track_reg;

endmodule

FILE: tb/tracking_resonator_frequency_tracker_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result from
// the accepted samples and compares it with what the block delivers.
module tracking_resonator_frequency_tracker_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_smoothed_real,
    input  logic signed [31:0] m_smoothed_imag,
    input  logic signed [31:0] m_delta_real,
    input  logic signed [31:0] m_delta_imag,
    input  logic signed [31:0] m_phase_step,
    input  logic               m_tracking,
    output int                 errors,
    output int                 outstanding
);

    typedef struct {
        logic signed [31:0] sm_re;
        logic signed [31:0] sm_im;
        logic signed [31:0] dl_re;
        logic signed [31:0] dl_im;
        logic signed [31:0] step;
        logic               track;
    } tracker_out_t;

    // Arctangent of 2^-i, 2^32 units per turn.
    localparam longint ATAN_TURNS [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    tracker_out_t expected_q [$];

    logic [15:0] w_alpha, w_beta, w_gamma;
    logic [30:0] nat_step;
    logic [31:0] pwr_thresh;
    logic [31:0] osc_phase, osc_step;
    longint      dem_re, dem_im, smo_re, smo_im;

    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint weight(input logic [15:0] w);
        return (w > 16'd32768) ? 64'sd32768 : longint'(w);
    endfunction

    // Half sums keep the two Q.60 products from overflowing.
    function automatic longint pair_to_q30(input longint p1, input longint p2);
        longint hs, lb;
        hs = (p1 >>> 1) + (p2 >>> 1);
        lb = longint'(p1[0]) + longint'(p2[0]);
        return clip32((hs + (lb >>> 1) + (64'sd1 <<< 28)) >>> 29);
    endfunction

    // Oscillator cos and sin in Q1.15 after quadrant folding.
    function automatic void osc_sincos(input logic [31:0] ph, output longint co,
                                       output longint si);
        logic [31:0] q, rem;
        longint x, y, z, xn, c, s;
        q = ((ph + 32'h2000_0000) >> 30) & 32'd3;
        rem = ph - (q << 30);
        z = longint'(signed'(rem));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURNS[i];
            end else begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURNS[i];
            end
            x = xn;
        end
        case (q)
            32'd0: begin c = x; s = y; end
            32'd1: begin c = -y; s = x; end
            32'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        co = clip16(rnd_shift(c, 15));
        si = clip16(rnd_shift(s, 15));
    endfunction

    // Angle of a vector; a zero vector has angle zero.
    function automatic longint vector_angle(input longint xi, input longint yi);
        longint x, y, z, t, xn;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 64'sh4000_0000;
            end else begin
                t = x; x = -y; y = t; z = -64'sh4000_0000;
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURNS[i];
            end else begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURNS[i];
            end
            x = xn;
        end
        return z;
    endfunction

    // Advances the predicted tracker by one sample.
    function automatic tracker_out_t track_sample(input logic signed [15:0] smp);
        tracker_out_t r;
        longint s30, a, b, g, zc, zs, pr, pi, sr, si, dr, di, dec;
        logic [63:0] power;
        logic        trk;
        s30 = longint'(smp) * 32768;
        a = weight(w_alpha);
        b = weight(w_beta);
        g = weight(w_gamma);
        osc_sincos(osc_phase, zc, zs);
        dem_re = clip32(rnd_shift((32768 - a) * dem_re * 32768 + (a * zc) * s30, 30));
        dem_im = clip32(rnd_shift((32768 - a) * dem_im * 32768 + (a * zs) * s30, 30));
        pr = smo_re;
        pi = smo_im;
        smo_re = clip32(rnd_shift((32768 - b) * pr + b * dem_re, 15));
        smo_im = clip32(rnd_shift((32768 - b) * pi + b * dem_im, 15));
        sr = smo_re;
        si = smo_im;
        dr = pair_to_q30(sr * pr, si * pi);
        di = pair_to_q30(si * pr, -(sr * pi));
        power = 64'(sr * sr) + 64'(si * si);
        trk = power > ({32'd0, pwr_thresh} << 30);
        if (trk) begin
            dec = rnd_shift(g * vector_angle(dr, di), 15);
            osc_step = osc_step - dec[31:0];
        end else begin
            osc_step = {1'b0, nat_step};
        end
        osc_phase = osc_phase + osc_step;
        r.sm_re = sr[31:0];
        r.sm_im = si[31:0];
        r.dl_re = dr[31:0];
        r.dl_im = di[31:0];
        r.step = osc_step;
        r.track = trk;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    assign outstanding = expected_q.size();

    initial errors = 0;

    always @(posedge aclk) begin
        tracker_out_t e;
        if (!aresetn) begin
            w_alpha = 16'd32768;
            w_beta = 16'd32768;
            w_gamma = 16'd0;
            nat_step = '0;
            pwr_thresh = 32'd1073742;
            osc_phase = '0;
            osc_step = '0;
            dem_re = 0;
            dem_im = 0;
            smo_re = 0;
            smo_im = 0;
            expected_q.delete();
        end else begin
            // Register writes; unknown indexes are ignored.
            if (cfg_we) begin
                case (cfg_index)
                    trft_pkg::REG_ALPHA:     w_alpha = cfg_wdata[15:0];
                    trft_pkg::REG_BETA:      w_beta = cfg_wdata[15:0];
                    trft_pkg::REG_GAMMA:     w_gamma = cfg_wdata[15:0];
                    trft_pkg::REG_NAT_STEP:  nat_step = cfg_wdata[30:0];
                    trft_pkg::REG_THRESHOLD: pwr_thresh = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(track_sample(s_sample));
            end
            // Result transfer against the oldest prediction.
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    compare_field("smoothed_real", e.sm_re, m_smoothed_real);
                    compare_field("smoothed_imag", e.sm_im, m_smoothed_imag);
                    compare_field("delta_real", e.dl_re, m_delta_real);
                    compare_field("delta_imag", e.dl_im, m_delta_imag);
                    compare_field("phase_step", e.step, m_phase_step);
                    compare_field("tracking", 32'(e.track), 32'(m_tracking));
                end
            end
        end
    end

endmodule

FILE: tb/tracking_resonator_frequency_tracker_core_test.sv
`timescale 1ns / 1ps

// Drives samples and register settings into the tracker; the checker does
// the prediction and the comparison.
module tracking_resonator_frequency_tracker_core_test;

    localparam logic [2:0] REG_UNUSED_A = 3'd5;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    localparam int PHASE_ITEMS = 245;
    localparam int SETTLE_CYCLES = 100;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_smoothed_real, m_smoothed_imag;
    logic signed [31:0] m_delta_real, m_delta_imag, m_phase_step;
    logic               m_tracking;
    int                 errors, outstanding;
    bit                 gaps_on;
    bit                 hold_req;

    tracking_resonator_frequency_tracker_core uut (.*);

    tracking_resonator_frequency_tracker_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The sample channel is idle before any register is written.
    task automatic set_all(input logic [31:0] a, input logic [31:0] b, input logic [31:0] g,
                           input logic [31:0] nat, input logic [31:0] thr);
        s_valid <= 1'b0;
        wait_drained();
        write_reg(trft_pkg::REG_ALPHA, a);
        write_reg(trft_pkg::REG_BETA, b);
        write_reg(trft_pkg::REG_GAMMA, g);
        write_reg(trft_pkg::REG_NAT_STEP, nat);
        write_reg(trft_pkg::REG_THRESHOLD, thr);
    endtask

    // One sample transfer; valid stays up when no gap follows.
    task automatic send_sample(input logic signed [15:0] v);
        s_valid <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Mostly tones near the oscillator's rest frequency, some noise and extremes.
    task automatic random_phase(input int n, input logic [31:0] nat);
        real freq, amp, ph;
        int  kind;
        freq = (real'(nat) / 4294967296.0) * (0.9 + 0.2 * ($urandom_range(0, 1000) / 1000.0));
        amp = real'($urandom_range(100, 32767));
        ph = 0.0;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_sample(16'(int'(amp * $sin(6.283185307179586 * ph))));
            end else if (kind < 9) begin
                send_sample(16'($urandom));
            end else begin
                send_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
            end
            ph = ph + freq;
            if ($urandom_range(0, 60) == 0) begin
                freq = freq * (0.95 + 0.1 * ($urandom_range(0, 100) / 100.0));
                amp = real'($urandom_range(100, 32767));
            end
        end
    endtask

    initial begin
        logic [31:0] nat;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_sample = '0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero threshold and full gamma: the first result has a zero phase step.
        write_reg(trft_pkg::REG_GAMMA, 32'd32768);
        write_reg(trft_pkg::REG_THRESHOLD, 32'd0);
        write_reg(REG_UNUSED_A, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_B, 32'h1234_5678);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(-16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        set_all(32'd0, 32'd65535, 32'd40000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        set_all(32'd65535, 32'd0, 32'd65535, 32'd0, 32'd0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh4321);
        set_all(32'd32768, 32'd32768, 32'd32768, 32'h4000_0000, 32'h8000_0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // Random phases, each with its own setting.
        for (int p = 0; p < 5; p++) begin
            nat = {1'b0, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                   : 31'($urandom_range(1 << 24, 1 << 29))};
            case (p)
                0: set_all(32'd8192, 32'd16384, 32'd4096, nat, 32'd1073742);
                1: set_all(32'd32768, 32'd32768, 32'd32768, nat, 32'd0);
                2: set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), nat, $urandom_range(0, 1 << 24));
                3: set_all(32'd2048, 32'd4096, 32'd1024, 32'h7FFF_FFFF, 32'd100000);
                default: set_all($urandom_range(1000, 32768), $urandom_range(1000, 32768),
                                 $urandom_range(0, 32768), nat, 32'd1073742);
            endcase
            if (p == 1) hold_req = 1'b1;
            if (p == 4) gaps_on = 1'b0;
            random_phase(PHASE_ITEMS, nat);
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
